>>> rtl/separable_gaussian_filter_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the separable Gaussian filter unit.
// ---------------------------------------------------------------------------
`ifndef SEPARABLE_GAUSSIAN_FILTER_UNIT_MACROS_SVH
`define SEPARABLE_GAUSSIAN_FILTER_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent, disabled in reset.
`define SGF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle, also active during reset.
`define SGF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/sgf_pkg.sv
// ---------------------------------------------------------------------------
// sgf_pkg
// Types, constants and helpers shared by the separable Gaussian filter.
// ---------------------------------------------------------------------------
package sgf_pkg;

  // Kernel geometry.
  localparam int HALF        = 5;
  localparam int TAPS        = 2 * HALF + 1;
  localparam int SLOTS       = 2 * HALF;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int LEAD_BITS   = $clog2(HALF + 1);
  localparam int COEFS       = 6;

  // Arithmetic widths.
  localparam int PIX_BITS    = 8;
  localparam int COEF_BITS   = 11;
  localparam int SCALE_SHIFT = 10;
  localparam int PROD_BITS   = PIX_BITS + COEF_BITS;
  localparam int SUM_BITS    = PROD_BITS + $clog2(TAPS);
  localparam int POS_BITS    = 13;
  localparam int ROW_BITS    = 12;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_CENTER = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_OFF5   = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 4'd7;

  typedef logic [PIX_BITS-1:0]  pix_t;
  typedef logic [COEF_BITS-1:0] coef_t;
  typedef logic [PROD_BITS-1:0] prod_t;
  typedef logic [SUM_BITS-1:0]  sum_t;

  localparam pix_t PIX_MAX = '1;

  // Distance of window lane j from the kernel center.
  function automatic int tap_dist(input int j);
    return (j < HALF) ? (HALF - j) : (j - HALF);
  endfunction

  // Scale a weighted sum down and clamp it to the pixel range.
  function automatic pix_t scale_sat(input sum_t s);
    logic [SUM_BITS-SCALE_SHIFT-1:0] q;
    q = s[SUM_BITS-1:SCALE_SHIFT];
    return (q > (SUM_BITS-SCALE_SHIFT)'(PIX_MAX)) ? PIX_MAX : q[PIX_BITS-1:0];
  endfunction

endpackage

>>> rtl/sgf_ram.sv
// ---------------------------------------------------------------------------
// sgf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents.
// ---------------------------------------------------------------------------
module sgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/separable_gaussian_filter_unit.sv
// After the stream word that completes it, a word passes the stage 1 to 3
// registers, then may wait in the output queue; results lag by 5 rows + 5 pixels.
// Throughput: one word per cycle while the output queue has room, set by the read
// of the ten line RAMs and the write back of the horizontal result the next cycle.
// Reset (synchronous, rst_n low): counters, window, queue and registers return
// to their defaults; the line RAMs are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// separable_gaussian_filter_unit
// Raster-stream separable blur: horizontal pass on a pixel window, vertical
// pass over ten row RAMs, a pipeline of stage registers and an eight-entry output queue.
// ---------------------------------------------------------------------------
module separable_gaussian_filter_unit import sgf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [PIX_BITS-1:0]     in_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIX_BITS-1:0]     out_filtered,
  output logic                    out_last_of_frame,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [POS_BITS-1:0] MAXW = POS_BITS'(MAX_WIDTH);
  localparam int FD = 8;
  localparam int FAW = $clog2(FD);

  // Configuration and stream position state.
  coef_t               coeff_r [COEFS];
  coef_t               width_r, height_r;
  pix_t                win_r [TAPS];
  logic [LEAD_BITS-1:0] lead_r;
  logic [AW-1:0]       in_col_r, hc_col_r;
  logic [ROW_BITS-1:0] in_row_r, hc_row_r;
  logic [SLOT_BITS-1:0] hslot_r;

  // Stage 1: horizontal products and line RAM read.
  prod_t               prod_h_r [TAPS];
  logic                wr1_r, e1_r, last1_r, fwd_r;
  logic [AW-1:0]       col1_r;
  logic [SLOT_BITS-1:0] slot1_r, fwd_slot_r;
  logic [TAPS-1:0]     vmask1_r;
  pix_t                hval_r;

  // Stage 2: vertical operands; stage 3: vertical products.
  pix_t                vpix_r [TAPS];
  logic                e2_r, last2_r;
  prod_t               prod_v_r [TAPS];
  logic                e3_r, last3_r;

  // Output queue.
  pix_t                fq_pix_r [FD];
  logic [FD-1:0]       fq_last_r;
  logic [FAW-1:0]      fq_wp_r, fq_rp_r;
  logic [FAW:0]        fq_cnt_r;

  logic [POS_BITS-1:0] w_eff, h_eff, col13, hrow13;
  logic [AW-1:0]       col;
  logic                accept, ignore, act, comp, emit, last;
  pix_t                win_nxt [TAPS];
  prod_t               prod_h_nxt [TAPS];
  logic [TAPS-1:0]     vmask_nxt;
  pix_t                rdata [SLOTS];
  pix_t                ram_fix [SLOTS];
  pix_t                vpix_nxt [TAPS];
  pix_t                hval, vres;
  sum_t                hsum, vsum;
  logic [FAW:0]        inflight;
  logic                push, pop;

  assign cfg_ready = 1'b1;
  assign inflight  = (FAW+1)'(e1_r) + (FAW+1)'(e2_r) + (FAW+1)'(e3_r);
  assign in_ready  = (fq_cnt_r + inflight) < (FAW+1)'(FD);
  assign accept    = in_valid && in_ready;

  // Effective frame size and the current horizontal center column.
  always_comb begin
    if (width_r == '0) begin
      w_eff = POS_BITS'(1);
    end else if (POS_BITS'(width_r) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = POS_BITS'(width_r);
    end
    h_eff  = (height_r == '0) ? POS_BITS'(1) : POS_BITS'(height_r);
    col13  = (POS_BITS'(hc_col_r) < w_eff) ? POS_BITS'(hc_col_r) : (w_eff - 1'b1);
    col    = col13[AW-1:0];
    hrow13 = POS_BITS'(hc_row_r);
  end

  // Item decode: idle drain, horizontal compute, output emit, frame end.
  always_comb begin
    ignore = in_op && (in_row_r == '0) && (in_col_r == '0) && (lead_r == '0);
    act    = accept && !ignore;
    comp   = (lead_r == LEAD_BITS'(HALF));
    emit   = comp && (hrow13 >= POS_BITS'(HALF)) && (hrow13 - POS_BITS'(HALF) < h_eff);
    last   = emit && (hrow13 - POS_BITS'(HALF) == h_eff - 1'b1) && (col13 == w_eff - 1'b1);
  end

  // Shifted window, masked horizontal products and vertical row masks.
  always_comb begin
    win_nxt[0] = in_op ? '0 : in_pixel;
    for (int j = 1; j < TAPS; j++) begin
      win_nxt[j] = win_r[j-1];
    end
    for (int j = 0; j < TAPS; j++) begin
      if ((col13 + POS_BITS'(HALF) >= POS_BITS'(j)) &&
          (col13 + POS_BITS'(HALF) < w_eff + POS_BITS'(j))) begin
        prod_h_nxt[j] = PROD_BITS'(win_nxt[j]) * PROD_BITS'(coeff_r[tap_dist(j)]);
      end else begin
        prod_h_nxt[j] = '0;
      end
      vmask_nxt[j] = (hrow13 + POS_BITS'(j) >= POS_BITS'(SLOTS)) &&
                     (hrow13 + POS_BITS'(j) < h_eff + POS_BITS'(SLOTS));
    end
  end

  // Configuration, window and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r[0] <= coef_t'(1024);
      for (int k = 1; k < COEFS; k++) begin
        coeff_r[k] <= '0;
      end
      width_r  <= coef_t'(1024);
      height_r <= coef_t'(1024);
      for (int k = 0; k < TAPS; k++) begin
        win_r[k] <= '0;
      end
      lead_r   <= '0;
      in_col_r <= '0;
      in_row_r <= '0;
      hc_col_r <= '0;
      hc_row_r <= '0;
      hslot_r  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index) inside
          [REG_COEFF_CENTER:REG_COEFF_OFF5]: coeff_r[cfg_index[2:0]] <= cfg_data;
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (act) begin
        if (last) begin
          // Frame end returns the stream to idle.
          for (int k = 0; k < TAPS; k++) begin
            win_r[k] <= '0;
          end
          lead_r   <= '0;
          in_col_r <= '0;
          in_row_r <= '0;
          hc_col_r <= '0;
          hc_row_r <= '0;
          hslot_r  <= '0;
        end else begin
          for (int k = 0; k < TAPS; k++) begin
            win_r[k] <= win_nxt[k];
          end
          if (POS_BITS'(in_col_r) + 1'b1 >= w_eff) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 1'b1;
          end else begin
            in_col_r <= in_col_r + 1'b1;
          end
          if (!comp) begin
            lead_r <= lead_r + 1'b1;
          end else if (POS_BITS'(hc_col_r) + 1'b1 >= w_eff) begin
            hc_col_r <= '0;
            hc_row_r <= hc_row_r + 1'b1;
            hslot_r  <= (hslot_r == SLOT_BITS'(SLOTS - 1)) ? '0 : hslot_r + 1'b1;
          end else begin
            hc_col_r <= hc_col_r + 1'b1;
          end
        end
      end
    end
  end

  // Stage 1 registers; forward the previous write when it hits this column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr1_r <= 1'b0;
      e1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      wr1_r <= act && comp && !last;
      e1_r  <= act && emit;
      fwd_r <= wr1_r && (col1_r == col);
    end
    fwd_slot_r <= slot1_r;
    col1_r     <= col;
    slot1_r    <= hslot_r;
    last1_r    <= last;
    vmask1_r   <= vmask_nxt;
    for (int k = 0; k < TAPS; k++) begin
      prod_h_r[k] <= prod_h_nxt[k];
    end
    hval_r <= hval;
  end

  // Horizontal result.
  always_comb begin
    hsum = '0;
    for (int k = 0; k < TAPS; k++) begin
      hsum = hsum + SUM_BITS'(prod_h_r[k]);
    end
    hval = scale_sat(hsum);
  end

  // One line RAM per row slot, all read at the center column.
  for (genvar g = 0; g < SLOTS; g++) begin : g_line
    sgf_ram #(
      .WIDTH(PIX_BITS),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (wr1_r && (slot1_r == SLOT_BITS'(g))),
      .waddr (col1_r),
      .wdata (hval),
      .raddr (col),
      .rdata (rdata[g])
    );
  end

  // Rotate slots into row order, oldest row first, with the new row last.
  always_comb begin
    logic [SLOT_BITS:0] idx;
    for (int s = 0; s < SLOTS; s++) begin
      ram_fix[s] = (fwd_r && (fwd_slot_r == SLOT_BITS'(s))) ? hval_r : rdata[s];
    end
    for (int i = 0; i < SLOTS; i++) begin
      idx = (SLOT_BITS+1)'(slot1_r) + (SLOT_BITS+1)'(i);
      if (idx >= (SLOT_BITS+1)'(SLOTS)) begin
        idx = idx - (SLOT_BITS+1)'(SLOTS);
      end
      vpix_nxt[i] = vmask1_r[i] ? ram_fix[idx[SLOT_BITS-1:0]] : '0;
    end
    vpix_nxt[SLOTS] = vmask1_r[SLOTS] ? hval : '0;
  end

  // Stages 2 and 3: vertical operands, then vertical products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_r <= 1'b0;
      e3_r <= 1'b0;
    end else begin
      e2_r <= e1_r;
      e3_r <= e2_r;
    end
    last2_r <= last1_r;
    last3_r <= last2_r;
    for (int k = 0; k < TAPS; k++) begin
      vpix_r[k]   <= vpix_nxt[k];
      prod_v_r[k] <= PROD_BITS'(vpix_r[k]) * PROD_BITS'(coeff_r[tap_dist(k)]);
    end
  end

  // Vertical result.
  always_comb begin
    vsum = '0;
    for (int k = 0; k < TAPS; k++) begin
      vsum = vsum + SUM_BITS'(prod_v_r[k]);
    end
    vres = scale_sat(vsum);
  end

  // Output queue; entries are reserved before an item is accepted.
  assign push = e3_r;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_wp_r  <= '0;
      fq_rp_r  <= '0;
      fq_cnt_r <= '0;
    end else begin
      if (push) begin
        fq_wp_r <= fq_wp_r + 1'b1;
      end
      if (pop) begin
        fq_rp_r <= fq_rp_r + 1'b1;
      end
      fq_cnt_r <= fq_cnt_r + (FAW+1)'(push) - (FAW+1)'(pop);
    end
    if (push) begin
      fq_pix_r[fq_wp_r]  <= vres;
      fq_last_r[fq_wp_r] <= last3_r;
    end
  end

  assign out_valid         = (fq_cnt_r != '0);
  assign out_filtered      = fq_pix_r[fq_rp_r];
  assign out_last_of_frame = fq_last_r[fq_rp_r];

endmodule

>>> rtl/sgf_checker.sv
// ---------------------------------------------------------------------------
// sgf_checker
// Port-level checks for the separable Gaussian filter unit.
// ---------------------------------------------------------------------------
`include "separable_gaussian_filter_unit_macros.svh"

module sgf_checker import sgf_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_op,
  input logic [PIX_BITS-1:0]     in_pixel,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [PIX_BITS-1:0]     out_filtered,
  input logic                    out_last_of_frame,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_IDX_BITS-1:0] cfg_index,
  input logic [COEF_BITS-1:0]    cfg_data
);

  // A stalled result word holds its value.
  `SGF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_filtered) && $stable(out_last_of_frame), "stalled output word changed")

  // The configuration port never back-pressures.
  `SGF_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

  // Right after reset the queue is empty and input is taken.
  `SGF_ASSERT_NOW(a_reset_empty, rst_n && $past(!rst_n), !out_valid && in_ready, "block not empty after reset")

endmodule

bind separable_gaussian_filter_unit sgf_checker u_sgf_checker (.*);

>>> tb/tb_separable_gaussian_filter_unit.sv
// ----------------------------------------------------------------------------
// Separable blur unit testbench
// Streams raster frames of assorted sizes and kernels through the unit. A
// directed table checks a tiny frame under the identity kernel; extreme and then
// random frames follow. Results are checked against table values or an in-bench
// model of the horizontal and vertical passes. The sender idles in bursts and the
// receiver stalls, including one long hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_separable_gaussian_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sgf_pkg::*;

  localparam int FRAME_W_MAX = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 420;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_op = 1'b0;
  logic [PIX_BITS-1:0]     in_pixel = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PIX_BITS-1:0]     out_filtered;
  logic                    out_last_of_frame;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0]    cfg_data = '0;

  separable_gaussian_filter_unit u_dut (.*);

  always #2 clk = ~clk;

  typedef struct {
    pix_t filt;
    bit   last;
  } blur_word_t;

  typedef struct {
    bit   drain;
    pix_t pix;
    bit   fixed;
    pix_t filt;
    bit   last;
  } table_row_t;

  // Model state: coefficients, frame size, window, row stores and positions.
  coef_t kcoef [COEFS];
  coef_t frame_w_reg;
  coef_t frame_h_reg;
  pix_t  win [TAPS];
  pix_t  row_store [SLOTS*FRAME_W_MAX];
  int    col_in, row_in, lead_cnt, hcol, hrow;

  blur_word_t pending_blur [$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int words_seen = 0;
  int frames_run = 0;

  // Sideband from the sender: a hand-typed expectation for the current word.
  bit   cur_fixed = 1'b0;
  pix_t cur_filt = '0;
  bit   cur_last = 1'b0;

  int burst_left = 0;
  bit hold_req = 1'b0;

  function automatic pix_t clamp_scaled(longint unsigned acc);
    longint unsigned q;
    q = acc >> SCALE_SHIFT;
    return (q > 255) ? 8'hFF : pix_t'(q);
  endfunction

  function automatic void blur_idle();
    for (int i = 0; i < TAPS; i++) win[i] = '0;
    col_in = 0;
    row_in = 0;
    lead_cnt = 0;
    hcol = 0;
    hrow = 0;
  endfunction

  // One stream word through both passes; at most one blurred pixel comes out.
  function automatic void blur_step(input bit drain, input pix_t px, output bit hit,
                                    output pix_t f, output bit lst);
    int w, h, col, r, cc, rr, k;
    longint unsigned acc, vacc;
    pix_t hv, val;
    hit = 1'b0;
    f = '0;
    lst = 1'b0;
    w = (frame_w_reg == 0) ? 1 : ((frame_w_reg > FRAME_W_MAX) ? FRAME_W_MAX : frame_w_reg);
    h = (frame_h_reg == 0) ? 1 : frame_h_reg;
    if (drain && row_in == 0 && col_in == 0 && lead_cnt == 0) return;
    for (int i = TAPS - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = drain ? '0 : px;
    if (lead_cnt < HALF) begin
      lead_cnt++;
    end else begin
      col = (hcol < w) ? hcol : w - 1;
      acc = 0;
      for (int d = -HALF; d <= HALF; d++) begin
        cc = col + d;
        k = (d < 0) ? -d : d;
        if (cc >= 0 && cc < w) acc += longint'(win[HALF-d]) * longint'(kcoef[k]);
      end
      hv = clamp_scaled(acc);
      if (hrow >= HALF && hrow - HALF < h) begin
        r = hrow - HALF;
        vacc = 0;
        for (int d = -HALF; d <= HALF; d++) begin
          rr = r + d;
          k = (d < 0) ? -d : d;
          if (rr >= 0 && rr < h) begin
            val = (d == HALF) ? hv : row_store[(rr % SLOTS) * FRAME_W_MAX + col];
            vacc += longint'(val) * longint'(kcoef[k]);
          end
        end
        lst = (r == h - 1) && (col == w - 1);
        f = clamp_scaled(vacc);
        hit = 1'b1;
        if (lst) begin
          blur_idle();
          return;
        end
      end
      row_store[(hrow % SLOTS) * FRAME_W_MAX + col] = hv;
      hcol++;
      if (hcol >= w) begin
        hcol = 0;
        hrow++;
      end
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d (word %0d)", what, got, want, words_seen);
    errors++;
  endtask

  // Monitor: applies register writes, predicts accepted words, checks results.
  always @(posedge clk) begin
    bit hit, lst;
    pix_t f;
    blur_word_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_COEFF_OFF5) kcoef[cfg_index - REG_COEFF_CENTER] = cfg_data;
        else if (cfg_index == REG_IMAGE_WIDTH) frame_w_reg = cfg_data;
        else if (cfg_index == REG_IMAGE_HEIGHT) frame_h_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        blur_step(in_op, in_pixel, hit, f, lst);
        if (cur_fixed) pending_blur.push_back('{cur_filt, cur_last});
        else if (hit) pending_blur.push_back('{f, lst});
      end
      if (out_valid && out_ready) begin
        words_seen++;
        if (pending_blur.size() == 0) begin
          report_mismatch("unexpected word", out_filtered, -1);
        end else begin
          e = pending_blur.pop_front();
          if (out_filtered !== e.filt) report_mismatch("filtered", out_filtered, e.filt);
          if (out_last_of_frame !== e.last)
            report_mismatch("last_of_frame", out_last_of_frame, e.last);
        end
      end
    end
  end

  // Receiver: one long hold-off on request, otherwise a shifting stall pattern.
  always @(negedge clk) begin
    static int hold_cnt = 0;
    static int mode = 0;
    if (cycles % 64 == 0) mode = $urandom_range(0, 2);
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready = 1'b0;
      hold_cnt++;
    end else begin
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = $urandom_range(0, 1);
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coef_t val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sender: bursts of words with random gaps between them.
  task automatic send_word(input bit drain, input pix_t px, input bit fixed,
                           input pix_t f, input bit lst);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 20);
    end
    in_valid = 1'b1;
    in_op = drain;
    in_pixel = px;
    cur_fixed = fixed;
    cur_filt = f;
    cur_last = lst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    cur_fixed = 1'b0;
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    while (pending_blur.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // One frame: kernel and size, then pixels, then the drain tail.
  task automatic run_frame(input coef_t w, input coef_t h, input coef_t k [COEFS]);
    int ew, eh;
    for (int i = 0; i < COEFS; i++)
      write_reg(REG_COEFF_CENTER + CFG_IDX_BITS'(i), k[i]);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    ew = (w == 0) ? 1 : ((w > FRAME_W_MAX) ? FRAME_W_MAX : w);
    eh = (h == 0) ? 1 : h;
    // Drain words before a frame starts are ignored.
    repeat ($urandom_range(0, 2)) send_word(1'b1, pix_t'($urandom), 1'b0, '0, 1'b0);
    for (int i = 0; i < ew * eh; i++)
      send_word($urandom_range(0, 11) == 0, pix_t'($urandom), 1'b0, '0, 1'b0);
    // Pixels past the frame act as drains.
    for (int i = 0; i < HALF * ew + HALF; i++)
      send_word($urandom_range(0, 2) != 0, pix_t'($urandom), 1'b0, '0, 1'b0);
    wait_idle();
    frames_run++;
  endtask

  function automatic void random_kernel(output coef_t k [COEFS]);
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < COEFS; i++) begin
      case (mode)
        0: k[i] = coef_t'($urandom_range(0, 1024));
        1: k[i] = (i == 0) ? coef_t'($urandom_range(200, 500))
                           : coef_t'($urandom_range(0, 400 >> i));
        2: k[i] = ($urandom_range(0, 1) == 0) ? 11'h7FF : 11'd0;
        default: k[i] = coef_t'($urandom_range(0, 2047));
      endcase
    end
  endfunction

  // Identity kernel on a 2x2 frame: each result is its pixel 15 words later.
  table_row_t dir_tab [20] = '{
    '{1'b1, 8'hA5, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'd0,  1'b0, 8'd0,   1'b0},
    '{1'b0, 8'hFF, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h5A, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'hAA, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'hFF, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'hFF, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h00, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'h81, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h7E, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h3C, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'hC3, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h01, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h80, 1'b0, 8'd0,   1'b0},
    '{1'b0, 8'h11, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'hEE, 1'b0, 8'd0,   1'b0},
    '{1'b1, 8'h00, 1'b1, 8'd0,   1'b0},
    '{1'b0, 8'hFF, 1'b1, 8'd255, 1'b0},
    '{1'b1, 8'h00, 1'b1, 8'd0,   1'b0},
    '{1'b1, 8'h00, 1'b1, 8'd170, 1'b1}
  };

  initial begin
    coef_t k [COEFS];
    kcoef = '{11'd1024, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0};
    frame_w_reg = 11'd1024;
    frame_h_reg = 11'd1024;
    foreach (row_store[i]) row_store[i] = '0;
    blur_idle();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table under the reset kernel.
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    foreach (dir_tab[i])
      send_word(dir_tab[i].drain, dir_tab[i].pix, dir_tab[i].fixed, dir_tab[i].filt,
                dir_tab[i].last);
    wait_idle();

    // Size and kernel extremes.
    k = '{11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF};
    run_frame(11'd0, 11'd0, k);
    k = '{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0};
    run_frame(11'd3, 11'd2, k);
    k = '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024};
    run_frame(11'd12, 11'd11, k);
    // A tall narrow frame under a long receiver hold-off.
    k = '{11'd260, 11'd210, 11'd110, 11'd35, 11'd7, 11'd1};
    hold_req = 1'b1;
    run_frame(11'd1, 11'd40, k);

    // Random frames, mostly small.
    while (items_sent < ITEM_TARGET) begin
      random_kernel(k);
      run_frame(coef_t'($urandom_range(1, 12)), coef_t'($urandom_range(1, 8)), k);
    end

    $display("ran %0d frames, %0d words in, %0d words out", frames_run, items_sent,
             words_seen);
    $display("covered zero-size and small frames, kernel extremes, drains, and back-pressure");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
